>>> hw/rtl/sfr_pkg.sv
// shared widths, register indexes and job descriptor for the stream find-and-replace unit
// no dependencies
package sfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int LEN_W      = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } cfg_reg_t;

    // one emission job: byte count and end-of-text flag
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             fin;
    } job_meta_t;

endpackage

>>> hw/rtl/sfr_ifs.sv
// valid/ready channel interfaces for text input, result output and configuration writes
// depends on sfr_pkg
interface sfr_text_if;
    import sfr_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              final_byte;
    modport source (output valid, text_byte, final_byte, input ready);
    modport sink   (input valid, text_byte, final_byte, output ready);
endinterface

interface sfr_result_if;
    import sfr_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              text_end;
    modport source (output valid, out_byte, run_last, text_end, input ready);
    modport sink   (input valid, out_byte, run_last, text_end, output ready);
endinterface

interface sfr_cfg_if;
    import sfr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/sfr_front.sv
// front end: configuration registers, match window and classification of each text byte
// into an emission job; depends on sfr_pkg and sfr_ifs
module sfr_front #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    sfr_text_if.sink            text,
    sfr_cfg_if.sink             cfg,
    input  logic                q_full,
    output logic                push,
    output sfr_pkg::job_meta_t  push_meta,
    output logic [((MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT)
                  * sfr_pkg::BYTE_W - 1:0] push_bytes
);
    import sfr_pkg::*;

    localparam int JOB_BYTES = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
    localparam int CNT_W     = $clog2(MAX_PATTERN + 1);

    logic [CFG_DATA_W-1:0] pat_bytes_reg;
    logic [LEN_W-1:0]      pat_len_reg;
    logic [CFG_DATA_W-1:0] rep_bytes_reg;
    logic [LEN_W-1:0]      rep_len_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [BYTE_W-1:0]     win_reg  [MAX_PATTERN];
    logic [BYTE_W-1:0]     win_next [MAX_PATTERN];
    logic [BYTE_W-1:0]     win_new  [MAX_PATTERN];

    logic             accept;
    logic             cfg_wr;
    logic [LEN_W-1:0] plen;
    logic [LEN_W-1:0] rlen;
    logic [LEN_W-1:0] count_ext;
    logic             full;
    logic             match;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v,
                                                 input logic [LEN_W-1:0] maxv);
        logic [LEN_W-1:0] r;
        r = v;
        if (r == '0)
        begin
            r = LEN_W'(1);
        end
        if (r > maxv)
        begin
            r = maxv;
        end
        return r;
    endfunction

    assign cfg.ready  = 1'b1;
    assign cfg_wr     = cfg.valid;
    assign text.ready = !q_full;
    assign accept     = text.valid && text.ready;

    assign plen      = sat_len(pat_len_reg, LEN_W'(MAX_PATTERN));
    assign rlen      = sat_len(rep_len_reg, LEN_W'(MAX_REPLACEMENT));
    assign count_ext = LEN_W'(count_reg) + LEN_W'(1);
    assign full      = (count_ext == plen);

    // window with the new byte placed after the held ones
    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            win_new[i] = (CNT_W'(i) == count_reg) ? text.text_byte : win_reg[i];
            if ((LEN_W'(i) < plen) && (win_new[i] != pat_bytes_reg[i*BYTE_W +: BYTE_W]))
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        push_bytes     = '0;
        push_meta.fin  = text.final_byte;
        push_meta.len  = count_ext;
        push           = accept && (full || text.final_byte);
        if (full && match)
        begin
            push_bytes    = rep_bytes_reg[JOB_BYTES*BYTE_W-1:0];
            push_meta.len = rlen;
        end
        else
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                push_bytes[i*BYTE_W +: BYTE_W] = win_new[i];
            end
            if (full && !text.final_byte)
            begin
                push_meta.len = LEN_W'(1);
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            win_next[i] = win_new[i];
        end
        if (cfg_wr && (cfg_reg_t'(cfg.index) == REG_PATTERN_LENGTH))
        begin
            count_next = '0;
        end
        else if (accept)
        begin
            priority if ((full && match) || text.final_byte)
            begin
                count_next = '0;
            end
            else if (full)
            begin
                // oldest byte leaves, count stays one below the pattern length
                for (int i = 0; i < MAX_PATTERN - 1; i++)
                begin
                    win_next[i] = win_new[i+1];
                end
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= LEN_W'(1);
            rep_bytes_reg <= '0;
            rep_len_reg   <= LEN_W'(1);
            count_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_wr)
            begin
                unique case (cfg_reg_t'(cfg.index))
                    REG_PATTERN_BYTES:      pat_bytes_reg <= cfg.data;
                    REG_PATTERN_LENGTH:     pat_len_reg   <= cfg.data[LEN_W-1:0];
                    REG_REPLACEMENT_BYTES:  rep_bytes_reg <= cfg.data;
                    REG_REPLACEMENT_LENGTH: rep_len_reg   <= cfg.data[LEN_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg <= win_next;
        end
    end

endmodule

>>> hw/rtl/sfr_queue.sv
// short first-in first-out queue of emission jobs between front and back end
// depends on nothing
module sfr_queue #(
    parameter int WIDTH = 73,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;

    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/sfr_back.sv
// back end: takes jobs from the queue and sends their bytes one transaction at a time
// depends on sfr_pkg and sfr_ifs
module sfr_back #(
    parameter int JOB_BYTES = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    input  sfr_pkg::job_meta_t                q_meta,
    input  logic [JOB_BYTES*sfr_pkg::BYTE_W-1:0] q_bytes,
    output logic                              q_pop,
    sfr_result_if.source                      result
);
    import sfr_pkg::*;

    logic                          cur_valid_reg;
    logic [JOB_BYTES*BYTE_W-1:0]   bytes_reg;
    logic [LEN_W-1:0]              left_reg;
    logic                          fin_reg;
    logic                          take;
    logic                          last;
    logic                          load;

    assign take  = result.valid && result.ready;
    assign last  = (left_reg == LEN_W'(1));
    assign load  = !q_empty && (!cur_valid_reg || (take && last));
    assign q_pop = load;

    assign result.valid    = cur_valid_reg;
    assign result.out_byte = bytes_reg[BYTE_W-1:0];
    assign result.run_last = last;
    assign result.text_end = last && fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            cur_valid_reg <= 1'b1;
        end
        else if (take && last)
        begin
            cur_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= q_bytes;
            left_reg  <= q_meta.len;
            fin_reg   <= q_meta.fin;
        end
        else if (take)
        begin
            bytes_reg <= bytes_reg >> BYTE_W;
            left_reg  <= left_reg - LEN_W'(1);
        end
    end

endmodule

>>> hw/rtl/stream_find_replace_unit.sv
// a job from an accepted text byte goes through the job queue into the back-end output register
// throughput: one text byte per cycle while each byte yields at most one result and result
// is ready; a match sends replacement_length bytes and the 2-entry job queue then stalls input
// reset: configuration returns to defaults, match window empties, queue and output go idle
// top level of the stream find-and-replace unit: front end, job queue, back end
// depends on sfr_pkg, sfr_ifs, sfr_front, sfr_queue, sfr_back
module stream_find_replace_unit #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    sfr_text_if.sink      text,
    sfr_cfg_if.sink       cfg,
    sfr_result_if.source  result
);
    import sfr_pkg::*;

    localparam int JOB_BYTES = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
    localparam int JOB_W     = JOB_BYTES * BYTE_W;
    localparam int Q_W       = JOB_W + $bits(job_meta_t);

    logic                push;
    job_meta_t           push_meta;
    logic [JOB_W-1:0]    push_bytes;
    logic                q_full;
    logic                q_empty;
    logic                q_pop;
    logic [Q_W-1:0]      q_data;
    job_meta_t           q_meta;
    logic [JOB_W-1:0]    q_bytes;

    assign q_meta  = q_data[Q_W-1:JOB_W];
    assign q_bytes = q_data[JOB_W-1:0];

    sfr_front #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .cfg        (cfg),
        .q_full     (q_full),
        .push       (push),
        .push_meta  (push_meta),
        .push_bytes (push_bytes)
    );

    sfr_queue #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_meta, push_bytes}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    sfr_back #(
        .JOB_BYTES (JOB_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_meta  (q_meta),
        .q_bytes (q_bytes),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

>>> hw/rtl/sfr_checker.sv
// port-level checks on the stream find-and-replace unit, bound to the top level
// depends on sfr_pkg and stream_find_replace_unit
module sfr_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       text_valid,
    input logic                       text_ready,
    input logic                       text_final,
    input logic                       result_valid,
    input logic                       result_ready,
    input logic [sfr_pkg::BYTE_W-1:0] result_out_byte,
    input logic                       result_run_last,
    input logic                       result_text_end
);
    import sfr_pkg::*;

    // stalled result stays offered
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            $stable(result_out_byte) && $stable(result_run_last) && $stable(result_text_end))
        else $error("result payload changed while stalled");

    // end of text always closes a run
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_text_end |-> result_run_last)
        else $error("text_end without run_last");

    // a final byte accepted on the input is always followed by a valid result
    a_final_flush: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && text_ready && text_final |-> ##2 result_valid)
        else $error("final byte gave no result");

endmodule

bind stream_find_replace_unit sfr_checker u_sfr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .text_valid      (text.valid),
    .text_ready      (text.ready),
    .text_final      (text.final_byte),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_out_byte (result.out_byte),
    .result_run_last (result.run_last),
    .result_text_end (result.text_end)
);

>>> test/stream_find_replace_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for stream_find_replace_unit: directed and random text, checked
// byte by byte against a predictor of the find-and-replace rewrite held in a scoreboard class
// depends on sfr_pkg, sfr_ifs and the stream_find_replace_unit rtl
module stream_find_replace_unit_tb;

    import sfr_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 3;
    localparam int QUIET_CYCLES  = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_ITEMS  = 160;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
        logic              text_end;
    } out_beat_t;

    class rewrite_scoreboard;
        logic [CFG_DATA_W-1:0] pat_word;
        logic [LEN_W-1:0]      pat_len_reg;
        logic [CFG_DATA_W-1:0] rep_word;
        logic [LEN_W-1:0]      rep_len_reg;
        logic [BYTE_W-1:0]     window[8];
        int                    held;
        out_beat_t             rewritten_bytes[$];
        int                    failures;

        function new();
            pat_word    = '0;
            pat_len_reg = 4'd1;
            rep_word    = '0;
            rep_len_reg = 4'd1;
            held        = 0;
            failures    = 0;
            clear_window();
        endfunction

        function void clear_window();
            foreach (window[i])
                window[i] = '0;
            held = 0;
        endfunction

        function int clamp_len(logic [LEN_W-1:0] raw);
            if (raw == 0)
                return 1;
            if (raw > 8)
                return 8;
            return int'(raw);
        endfunction

        function int pattern_len();
            return clamp_len(pat_len_reg);
        endfunction

        function logic [BYTE_W-1:0] pattern_byte(int i);
            return pat_word[8*i +: 8];
        endfunction

        function int pending();
            return rewritten_bytes.size();
        endfunction

        function void write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PATTERN_BYTES:     pat_word = data;
                REG_PATTERN_LENGTH:
                begin
                    pat_len_reg = data[LEN_W-1:0];
                    clear_window();
                end
                REG_REPLACEMENT_BYTES: rep_word = data;
                default:               rep_len_reg = data[LEN_W-1:0];
            endcase
        endfunction

        function logic [BYTE_W-1:0] pop_oldest();
            logic [BYTE_W-1:0] b;
            b = window[0];
            for (int i = 1; i < 8; i++)
                window[i-1] = window[i];
            window[7] = '0;
            if (held > 0)
                held--;
            return b;
        endfunction

        // notes one accepted text byte and queues the bytes it rewrites to
        function void predict_rewrite(logic [BYTE_W-1:0] b, logic fin);
            int        plen;
            int        rlen;
            bit        hit;
            out_beat_t beat;
            out_beat_t run[$];
            plen = clamp_len(pat_len_reg);
            rlen = clamp_len(rep_len_reg);
            beat.run_last = 1'b0;
            beat.text_end = 1'b0;
            if (held >= plen)
                held = 0;
            window[held] = b;
            held++;
            if (held == plen)
            begin
                hit = 1'b1;
                for (int i = 0; i < plen; i++)
                    if (window[i] != pat_word[8*i +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    for (int i = 0; i < rlen; i++)
                    begin
                        beat.out_byte = rep_word[8*i +: 8];
                        run.push_back(beat);
                    end
                    clear_window();
                end
                else
                begin
                    beat.out_byte = pop_oldest();
                    run.push_back(beat);
                end
            end
            if (fin)
            begin
                while (held > 0 && run.size() < 8)
                begin
                    beat.out_byte = pop_oldest();
                    run.push_back(beat);
                end
                clear_window();
            end
            if (run.size() > 0)
            begin
                run[run.size()-1].run_last = 1'b1;
                run[run.size()-1].text_end = fin;
            end
            foreach (run[i])
                rewritten_bytes.push_back(run[i]);
        endfunction

        function void check_rewrite(logic [BYTE_W-1:0] ob, logic rl, logic te);
            out_beat_t want;
            if (rewritten_bytes.size() == 0)
            begin
                $error("unexpected result transaction: out_byte %02h run_last %0b text_end %0b",
                       ob, rl, te);
                failures++;
                return;
            end
            want = rewritten_bytes.pop_front();
            if (ob !== want.out_byte)
            begin
                $error("out_byte mismatch: expected %02h, actual %02h", want.out_byte, ob);
                failures++;
            end
            if (rl !== want.run_last)
            begin
                $error("run_last mismatch: expected %0b, actual %0b", want.run_last, rl);
                failures++;
            end
            if (te !== want.text_end)
            begin
                $error("text_end mismatch: expected %0b, actual %0b", want.text_end, te);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    int   text_items;
    int   cycle_count;

    rewrite_scoreboard sb;

    sfr_text_if   text_ch ();
    sfr_cfg_if    cfg_ch ();
    sfr_result_if result_ch ();

    stream_find_replace_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .cfg    (cfg_ch),
        .result (result_ch)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** stream_find_replace_unit: FAILED **");
            $finish;
        end
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    task automatic push_text_byte(input logic [BYTE_W-1:0] b, input logic fin);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_ch.valid      <= 1'b1;
        text_ch.text_byte  <= b;
        text_ch.final_byte <= fin;
        do
            @(posedge clk);
        while (!text_ch.ready);
        sb.predict_rewrite(b, fin);
        text_items++;
    endtask

    task automatic settle();
        @(negedge clk);
        text_ch.valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.write_register(idx, data);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic setup_match(input logic [CFG_DATA_W-1:0] pat, input logic [LEN_W-1:0] plen,
                               input logic [CFG_DATA_W-1:0] rep, input logic [LEN_W-1:0] rlen);
        write_register(REG_PATTERN_BYTES, pat);
        write_register(REG_PATTERN_LENGTH, {60'd0, plen});
        write_register(REG_REPLACEMENT_BYTES, rep);
        write_register(REG_REPLACEMENT_LENGTH, {60'd0, rlen});
    endtask

    function automatic logic [LEN_W-1:0] draw_len();
        case ($urandom_range(0, 9))
            0:       return 4'd0;
            1:       return LEN_W'($urandom_range(9, 15));
            2:       return 4'd8;
            default: return LEN_W'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic random_setup(output logic [BYTE_W-1:0] sym[3]);
        logic [CFG_DATA_W-1:0] pat;
        logic [CFG_DATA_W-1:0] plen_word;
        logic [CFG_DATA_W-1:0] rlen_word;
        foreach (sym[i])
            sym[i] = BYTE_W'($urandom_range(0, 255));
        for (int i = 0; i < 8; i++)
            pat[8*i +: 8] = ($urandom_range(0, 4) != 0) ? sym[$urandom_range(0, 2)]
                                                        : BYTE_W'($urandom_range(0, 255));
        // upper bits of the length words are ignored by the block
        plen_word = {$urandom, $urandom};
        rlen_word = {$urandom, $urandom};
        plen_word[LEN_W-1:0] = draw_len();
        rlen_word[LEN_W-1:0] = draw_len();
        write_register(REG_PATTERN_BYTES, pat);
        write_register(REG_PATTERN_LENGTH, plen_word);
        write_register(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
        write_register(REG_REPLACEMENT_LENGTH, rlen_word);
    endtask

    // tidy texts are built from pattern copies, prefixes, alphabet bytes and random bytes
    task automatic random_text(input logic [BYTE_W-1:0] sym[3], input bit tidy, input bit closed);
        logic [BYTE_W-1:0] bytes_q[$];
        int                target;
        int                plen;
        int                cut;
        plen   = sb.pattern_len();
        target = $urandom_range(1, 14);
        while (bytes_q.size() < target)
        begin
            if (!tidy)
                bytes_q.push_back(BYTE_W'($urandom_range(0, 255)));
            else
                case ($urandom_range(0, 4))
                    0, 1:
                        for (int i = 0; i < plen; i++)
                            bytes_q.push_back(sb.pattern_byte(i));
                    2:
                    begin
                        cut = (plen > 1) ? $urandom_range(1, plen - 1) : 1;
                        for (int i = 0; i < cut; i++)
                            bytes_q.push_back(sb.pattern_byte(i));
                    end
                    3:       bytes_q.push_back(sym[$urandom_range(0, 2)]);
                    default: bytes_q.push_back(BYTE_W'($urandom_range(0, 255)));
                endcase
        end
        foreach (bytes_q[i])
            push_text_byte(bytes_q[i], closed && (i == bytes_q.size() - 1));
    endtask

    // result side: random back-pressure, every transaction checked
    initial
    begin
        int gap;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            @(negedge clk);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid && result_ch.ready));
            sb.check_rewrite(result_ch.out_byte, result_ch.run_last, result_ch.text_end);
        end
    end

    initial
    begin
        logic [BYTE_W-1:0] sym[3];
        sb                 = new();
        calm               = 1'b0;
        text_items         = 0;
        rst_n              = 1'b0;
        text_ch.valid      = 1'b0;
        text_ch.text_byte  = '0;
        text_ch.final_byte = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_PATTERN_BYTES;
        cfg_ch.data        = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // default registers: pattern and replacement are a single zero byte
        push_text_byte(8'h00, 1'b0);
        push_text_byte(8'hff, 1'b0);
        push_text_byte(8'h00, 1'b1);
        settle();

        // two-byte pattern, oversized replacement length saturates to eight
        setup_match(64'h4241, 4'd2, {64{1'b1}}, 4'd15);
        push_text_byte(8'h41, 1'b0);
        push_text_byte(8'h42, 1'b0);
        push_text_byte(8'h41, 1'b0);
        push_text_byte(8'h41, 1'b0);
        push_text_byte(8'h42, 1'b0);
        push_text_byte(8'h41, 1'b1);
        settle();

        // zero pattern length acts as one, full replacement on the final byte
        setup_match(64'h0, 4'd0, 64'h0807060504030201, 4'd8);
        push_text_byte(8'h00, 1'b1);
        push_text_byte(8'hff, 1'b0);
        push_text_byte(8'h80, 1'b1);
        settle();

        // full window without a match, flushed by the final byte
        setup_match({64{1'b1}}, 4'd8, 64'h5a, 4'd1);
        repeat (7) push_text_byte(8'hff, 1'b0);
        push_text_byte(8'h00, 1'b1);
        settle();

        // writes while a partial match is held in the window
        setup_match(64'h7a7978, 4'd3, 64'h51, 4'd1);
        push_text_byte(8'h78, 1'b0);
        push_text_byte(8'h79, 1'b0);
        settle();
        write_register(REG_REPLACEMENT_BYTES, 64'h52);
        push_text_byte(8'h7a, 1'b0);
        push_text_byte(8'h78, 1'b0);
        push_text_byte(8'h79, 1'b0);
        settle();
        write_register(REG_PATTERN_LENGTH, 64'd3);
        push_text_byte(8'h7a, 1'b1);

        while (text_items < RANDOM_ITEMS)
        begin
            settle();
            calm = ($urandom_range(0, 3) == 0);
            random_setup(sym);
            repeat ($urandom_range(1, 3))
                random_text(sym, $urandom_range(0, 4) != 0, $urandom_range(0, 7) != 0);
        end

        @(negedge clk);
        text_ch.valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("** stream_find_replace_unit: PASSED **");
        else
            $display("** stream_find_replace_unit: FAILED **");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_ifs.sv
hw/rtl/sfr_front.sv
hw/rtl/sfr_queue.sv
hw/rtl/sfr_back.sv
hw/rtl/stream_find_replace_unit.sv
hw/rtl/sfr_checker.sv
test/stream_find_replace_unit_tb.sv
